>>> rtl/core/skew_matrix_mutation_top_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef SKEW_MATRIX_MUTATION_TOP_MACROS_SVH
`define SKEW_MATRIX_MUTATION_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/smm_pkg.sv
package smm_pkg;

   localparam int ENTRY_W   = 16;
   localparam int PROD_W    = 32;
   localparam int SUM_W     = 34;
   localparam int DEF_MAX_N = 8;

   localparam int SIZE_W = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MUTATE = 2'd2;

   // new entry must lie strictly inside these bounds
   localparam logic signed [SUM_W-1:0] ENTRY_LOW  = -34'sd32768;
   localparam logic signed [SUM_W-1:0] ENTRY_HIGH = 34'sd32768;

   typedef struct packed {
      logic vld;         // sweep step issued this cycle
      logic region;      // entry lies inside the n by n matrix
      logic pivot_line;  // entry lies on pivot row or pivot column
   } smm_ctl_type;

endpackage

>>> rtl/core/smm_entry_update.sv
module smm_entry_update
   import smm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  smm_ctl_type               ctl,
   input  logic signed [ENTRY_W-1:0] bik,
   input  logic signed [ENTRY_W-1:0] bkj,
   input  logic signed [ENTRY_W-1:0] b,
   output logic                      upd_vld,
   output logic        [ENTRY_W-1:0] upd_value,
   output logic                      upd_ovf
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic vld_ff, vld_in;
   logic add_ff, add_in;
   logic sub_ff, sub_in;
   logic neg_ff, neg_in;
   logic chk_ff, chk_in;

   logic signed [SUM_W-1:0] b_ext;
   logic signed [SUM_W-1:0] p_ext;
   logic signed [SUM_W-1:0] x;

   // stage 1: product of the snapshot pair, only one sign case can contribute
   always_comb begin
      prod_in = PROD_W'(bik) * PROD_W'(bkj);
      vld_in  = ctl.vld;
      chk_in  = ctl.region;
      neg_in  = ctl.region && ctl.pivot_line;
      add_in  = ctl.region && !ctl.pivot_line && (bik > 0) && (bkj > 0);
      sub_in  = ctl.region && !ctl.pivot_line && (bik < 0) && (bkj < 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      prod_ff <= prod_in;
      add_ff  <= add_in;
      sub_ff  <= sub_in;
      neg_ff  <= neg_in;
      chk_ff  <= chk_in;
   end

   // stage 2: combine with the entry read from the active bank
   always_comb begin
      b_ext = SUM_W'(b);
      p_ext = SUM_W'(prod_ff);
      if (neg_ff) begin
         x = -b_ext;
      end else if (add_ff) begin
         x = b_ext + p_ext;
      end else if (sub_ff) begin
         x = b_ext - p_ext;
      end else begin
         x = b_ext;
      end
   end

   assign upd_vld   = vld_ff;
   assign upd_value = x[ENTRY_W-1:0];
   assign upd_ovf   = vld_ff && chk_ff && ((x <= ENTRY_LOW) || (x >= ENTRY_HIGH));

endmodule

>>> rtl/core/skew_matrix_mutation_top.sv
// Exchange-matrix mutation engine. Items are taken when start is high and busy
// is low; every item returns exactly one result on rsp_strobe, which the
// receiver cannot stall. Write, read and no-op items (and a mutation whose pivot
// is outside the matrix) answer in the cycle after acceptance and a new item may
// be started in that same cycle. A mutation holds busy until it is done and
// answers in the same cycle that busy drops. Its length is set by the single
// read port of the two-bank matrix memory: the pivot row and column are
// snapshotted one entry per cycle, then every entry of the active bank is read,
// updated and written into the other bank at one entry per cycle. The banks swap
// only if every updated entry lies strictly between -32768 and 32768.
`include "skew_matrix_mutation_top_macros.svh"

module skew_matrix_mutation_top
   import smm_pkg::*;
#(
   parameter int MAX_N = DEF_MAX_N
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic        [KIND_W-1:0]     req_kind,
   input  logic        [2:0]            req_row,
   input  logic        [2:0]            req_col,
   input  logic signed [ENTRY_W-1:0]    req_value,
   input  logic        [2:0]            req_pivot,
   output logic                         rsp_strobe,
   output logic signed [ENTRY_W-1:0]    rsp_read_value,
   output logic                         rsp_overflow,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic        [CSR_ADDR_W-1:0] paddr,
   input  logic        [CSR_DATA_W-1:0] pwdata,
   output logic        [CSR_DATA_W-1:0] prdata,
   output logic                         pready
);

   localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DEPTH = MAX_N * MAX_N;
   localparam int AW    = $clog2(DEPTH);
   localparam int N_W   = $clog2(MAX_N + 1);
   localparam int CW    = (N_W > SIZE_W) ? N_W : SIZE_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_N - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SNAP  = 5'b00010,
      ST_GAP   = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_LAST  = 5'b10000
   } state_type;

   // both banks, bank bit on top of the entry address
   logic [ENTRY_W-1:0] matrix_mem_ff [2**(AW+1)];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] row_copy_ff [MAX_N];
   logic [ENTRY_W-1:0] col_copy_ff [MAX_N];

   state_type state_ff, state_in;
   logic active_bank_ff, active_bank_in;
   logic [SIZE_W-1:0] matrix_size_ff, matrix_size_in;
   logic [IDX_W-1:0] pivot_ff, pivot_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic sel_ff, sel_in;
   logic ovf_ff, ovf_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_mem_ff, rsp_mem_in;
   logic rsp_ovf_ff, rsp_ovf_in;
   logic sn_vld_ff, sn_vld_in;
   logic sn_sel_ff, sn_sel_in;
   logic [IDX_W-1:0] sn_idx_ff, sn_idx_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;

   logic [CW-1:0] n_eff;
   logic accept;
   logic req_in_range;
   logic pivot_in_range;
   logic [IDX_W-1:0] row_idx;
   logic [IDX_W-1:0] col_idx;
   logic [IDX_W-1:0] req_pivot_idx;
   logic [AW:0] rd_addr;
   logic mem_we;
   logic [AW:0] mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic csr_write;
   logic [0:0] csr_index;

   smm_ctl_type upd_ctl;
   logic upd_vld;
   logic [ENTRY_W-1:0] upd_value;
   logic upd_ovf;
   logic ovf_total;

   function automatic logic [AW-1:0] entry_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return AW'(AW'(r) * AW'(MAX_N) + AW'(c));
   endfunction

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign prdata    = (csr_index == REG_MATRIX_SIZE) ? CSR_DATA_W'(matrix_size_ff) : '0;

   always_comb begin
      matrix_size_in = matrix_size_ff;
      if (csr_write && (csr_index == REG_MATRIX_SIZE)) begin
         matrix_size_in = pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      if (matrix_size_ff == '0) begin
         n_eff = CW'(1);
      end else if (CW'(matrix_size_ff) > CW'(MAX_N)) begin
         n_eff = CW'(MAX_N);
      end else begin
         n_eff = CW'(matrix_size_ff);
      end
   end

   // ---------------- request decode ----------------
   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign row_idx        = IDX_W'(req_row);
   assign col_idx        = IDX_W'(req_col);
   assign req_pivot_idx  = IDX_W'(req_pivot);
   assign req_in_range   = (CW'(req_row) < n_eff) && (CW'(req_col) < n_eff);
   assign pivot_in_range = CW'(req_pivot) < n_eff;

   // ---------------- read address ----------------
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  rd_addr = {active_bank_ff, entry_addr(row_idx, col_idx)};
         ST_SNAP:  rd_addr = sel_ff ? {active_bank_ff, entry_addr(i_ff, pivot_ff)}
                                    : {active_bank_ff, entry_addr(pivot_ff, i_ff)};
         ST_SWEEP: rd_addr = {active_bank_ff, entry_addr(i_ff, j_ff)};
         default:  rd_addr = {active_bank_ff, {AW{1'b0}}};
      endcase
   end

   // ---------------- entry update unit ----------------
   always_comb begin
      upd_ctl.vld        = (state_ff == ST_SWEEP);
      upd_ctl.region     = (CW'(i_ff) < n_eff) && (CW'(j_ff) < n_eff);
      upd_ctl.pivot_line = (i_ff == pivot_ff) || (j_ff == pivot_ff);
   end

   smm_entry_update u_update (
      .clock     (clock),
      .reset     (reset),
      .ctl       (upd_ctl),
      .bik       ($signed(col_copy_ff[i_ff])),
      .bkj       ($signed(row_copy_ff[j_ff])),
      .b         ($signed(rd_data_ff)),
      .upd_vld   (upd_vld),
      .upd_value (upd_value),
      .upd_ovf   (upd_ovf)
   );

   assign ovf_total = ovf_ff || upd_ovf;

   // ---------------- memory write port ----------------
   always_comb begin
      mem_we = 1'b0;
      mem_wa = {active_bank_ff, entry_addr(row_idx, col_idx)};
      mem_wd = req_value;
      if (accept && (req_kind == KIND_WRITE) && req_in_range) begin
         mem_we = 1'b1;
      end else if (upd_vld) begin
         // sweep results always land in the inactive bank
         mem_we = 1'b1;
         mem_wa = {~active_bank_ff, s1_addr_ff};
         mem_wd = upd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= matrix_mem_ff[rd_addr];
   end

   // snapshot data returns in the cycle after its read
   always_ff @(posedge clock) begin
      if (sn_vld_ff) begin
         if (sn_sel_ff) begin
            col_copy_ff[sn_idx_ff] <= rd_data_ff;
         end else begin
            row_copy_ff[sn_idx_ff] <= rd_data_ff;
         end
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      active_bank_in = active_bank_ff;
      pivot_in       = pivot_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      sel_in         = sel_ff;
      ovf_in         = upd_vld ? ovf_total : ovf_ff;
      rsp_valid_in   = 1'b0;
      rsp_mem_in     = 1'b0;
      rsp_ovf_in     = 1'b0;
      sn_vld_in      = (state_ff == ST_SNAP);
      sn_sel_in      = sel_ff;
      sn_idx_in      = i_ff;
      s1_addr_in     = entry_addr(i_ff, j_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_kind == KIND_MUTATE) && pivot_in_range) begin
                  state_in = ST_SNAP;
                  pivot_in = req_pivot_idx;
                  i_in     = '0;
                  sel_in   = 1'b0;
                  ovf_in   = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_mem_in   = (req_kind == KIND_READ) && req_in_range;
               end
            end
         end
         ST_SNAP: begin
            // pivot row entry first, then pivot column entry, per index
            if (!sel_ff) begin
               sel_in = 1'b1;
            end else begin
               sel_in = 1'b0;
               if (CW'(i_ff) == n_eff - CW'(1)) begin
                  state_in = ST_GAP;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end
         ST_GAP: begin
            state_in = ST_SWEEP;
            i_in     = '0;
            j_in     = '0;
         end
         ST_SWEEP: begin
            // the full bank is swept so entries outside n carry over
            if (j_ff == IDX_LAST) begin
               j_in = '0;
               if (i_ff == IDX_LAST) begin
                  state_in = ST_LAST;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_LAST: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ovf_in   = ovf_total;
            if (!ovf_total) begin
               active_bank_in = ~active_bank_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_bank_ff <= 1'b0;
         matrix_size_ff <= SIZE_RESET;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         sn_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_bank_ff <= active_bank_in;
         matrix_size_ff <= matrix_size_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         sn_vld_ff      <= sn_vld_in;
      end
      pivot_ff   <= pivot_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      sel_ff     <= sel_in;
      rsp_mem_ff <= rsp_mem_in;
      rsp_ovf_ff <= rsp_ovf_in;
      sn_sel_ff  <= sn_sel_in;
      sn_idx_ff  <= sn_idx_in;
      s1_addr_ff <= s1_addr_in;
   end

   // ---------------- result ----------------
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_read_value = rsp_mem_ff ? $signed(rd_data_ff) : '0;
   assign rsp_overflow   = rsp_ovf_ff;

   // ---------------- checks ----------------
   `SMM_ASSERT_NOW(a_mutate_done_rsp, $fell(busy) && !$past(reset), rsp_strobe, "mutation ended without a result")
   `SMM_ASSERT_NEXT(a_short_item_rsp, accept && (req_kind != KIND_MUTATE), rsp_strobe, "short transaction gave no result")
   `SMM_ASSERT_NOW(a_swap_clean, !$stable(active_bank_ff) && !$past(reset), rsp_strobe && !rsp_overflow, "bank swap without a clean result")
   `SMM_ASSERT_NOW(a_no_rsp_busy, busy, !rsp_strobe, "result while a mutation is in progress")

endmodule

>>> sim/tb_skew_matrix_mutation_top.sv
module tb_skew_matrix_mutation_top
   import smm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM = DEF_MAX_N;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam longint ENTRY_LIMIT = 32768;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = CSR_ADDR_W'(4 * REG_MATRIX_SIZE);

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [2:0]                row;
      logic [2:0]                col;
      logic signed [ENTRY_W-1:0] value;
      logic [2:0]                pivot;
   } matrix_cmd_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] read_value;
      logic                      overflow;
   } matrix_rsp_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic        [KIND_W-1:0]     req_kind = '0;
   logic        [2:0]            req_row = '0;
   logic        [2:0]            req_col = '0;
   logic signed [ENTRY_W-1:0]    req_value = '0;
   logic        [2:0]            req_pivot = '0;
   logic                         rsp_strobe;
   logic signed [ENTRY_W-1:0]    rsp_read_value;
   logic                         rsp_overflow;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic        [CSR_ADDR_W-1:0] paddr = '0;
   logic        [CSR_DATA_W-1:0] pwdata = '0;
   logic        [CSR_DATA_W-1:0] prdata;
   logic                         pready;

   // predicted block state: two banks of DIM*DIM entries, bank b at offset b*DIM*DIM
   logic signed [ENTRY_W-1:0] bank_mem [2*DIM*DIM];
   bit                        bank_sel = 1'b0;
   logic [SIZE_W-1:0]         size_csr = SIZE_RESET;

   matrix_rsp_type pending_rsp_q [$];
   matrix_rsp_type front_rsp;
   int          mismatch_count = 0;
   int          rsp_index = 0;
   int          item_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;

   skew_matrix_mutation_top #(
      .MAX_N(DIM)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .req_pivot      (req_pivot),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_overflow   (rsp_overflow),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("skew_matrix_mutation_top verification failed");
         $finish;
      end
   end

   function automatic int active_size();
      if (size_csr == 0) return 1;
      if (size_csr > DIM) return DIM;
      return int'(size_csr);
   endfunction

   // Updates the predicted state for one accepted transaction and returns its result.
   function automatic matrix_rsp_type apply_matrix_cmd(input matrix_cmd_type c);
      matrix_rsp_type r;
      logic signed [ENTRY_W-1:0] next_mem [DIM*DIM];
      longint b, bik, bkj, x;
      int n, k, cur, nxt;
      r = '0;
      n = active_size();
      cur = bank_sel ? DIM*DIM : 0;
      nxt = bank_sel ? 0 : DIM*DIM;
      k = int'(c.pivot);
      case (c.kind)
         KIND_WRITE: begin
            if (c.row < n && c.col < n) bank_mem[cur + c.row*DIM + c.col] = c.value;
         end
         KIND_READ: begin
            if (c.row < n && c.col < n) r.read_value = bank_mem[cur + c.row*DIM + c.col];
         end
         KIND_MUTATE: begin
            if (k < n) begin
               for (int i = 0; i < DIM*DIM; i++) next_mem[i] = bank_mem[cur + i];
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++) begin
                     b = bank_mem[cur + i*DIM + j];
                     if (i == k || j == k) begin
                        x = -b;
                     end else begin
                        bik = bank_mem[cur + i*DIM + k];
                        bkj = bank_mem[cur + k*DIM + j];
                        x = b + (bik > 0 ? bik : 0) * (bkj > 0 ? bkj : 0)
                              - (bik < 0 ? -bik : 0) * (bkj < 0 ? -bkj : 0);
                     end
                     if (x <= -ENTRY_LIMIT || x >= ENTRY_LIMIT) r.overflow = 1'b1;
                     else next_mem[i*DIM + j] = ENTRY_W'(x);
                  end
               end
               // the shadow bank only becomes visible when every entry fits
               if (!r.overflow) begin
                  for (int i = 0; i < DIM*DIM; i++) bank_mem[nxt + i] = next_mem[i];
                  bank_sel = ~bank_sel;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic matrix_cmd_type make_cmd(input logic [KIND_W-1:0] kind,
                                               input logic [2:0] row, input logic [2:0] col,
                                               input logic signed [ENTRY_W-1:0] value,
                                               input logic [2:0] pivot);
      matrix_cmd_type c;
      c.kind = kind;
      c.row = row;
      c.col = col;
      c.value = value;
      c.pivot = pivot;
      return c;
   endfunction

   function automatic logic signed [ENTRY_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return ENTRY_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return -16'sd32767;
               2: return 16'sh8000;
               default: return '0;
            endcase
         end
         default: return ENTRY_W'(int'($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   // mostly inside the active region, now and then anywhere
   function automatic int pick_index(input int n);
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, DIM-1));
      return int'($urandom_range(0, n-1));
   endfunction

   task automatic report_mismatch(input string what, input matrix_rsp_type exp_r,
                                  input matrix_rsp_type act_r);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s) at result %0d: expected read_value=%0d overflow=%0b,",
                  what, rsp_index, exp_r.read_value, exp_r.overflow,
                  " got read_value=%0d overflow=%0b",
                  act_r.read_value, act_r.overflow);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected", '0, {rsp_read_value, rsp_overflow});
         end else begin
            front_rsp = pending_rsp_q[0];
            pending_rsp_q.delete(0);
            if (front_rsp.read_value !== rsp_read_value
                || front_rsp.overflow !== rsp_overflow)
               report_mismatch("data", front_rsp, {rsp_read_value, rsp_overflow});
         end
         rsp_index++;
      end
   end

   // start stays high between back-to-back transactions; it is lowered only for a gap
   task automatic send_item(input matrix_cmd_type c);
      int n;
      n = active_size();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= c.kind;
      req_row <= c.row;
      req_col <= c.col;
      req_value <= c.value;
      req_pivot <= c.pivot;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp_q.insert(pending_rsp_q.size(), apply_matrix_cmd(c));
      if (!(c.kind == KIND_UNUSED || (c.kind == KIND_WRITE && (c.row >= n || c.col >= n))))
         item_count++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_matrix_size(input logic [SIZE_W-1:0] sz);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SIZE_ADDR;
      pwdata <= {$urandom} & ~32'hF | CSR_DATA_W'(sz);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      size_csr = sz;
   endtask

   // skew-symmetric fill of the n by n region with small entries, zero diagonal
   task automatic load_skew(input int n);
      logic signed [ENTRY_W-1:0] upper [DIM*DIM];
      logic signed [ENTRY_W-1:0] v;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (i == j) begin
               v = '0;
            end else if (j > i) begin
               v = ENTRY_W'(int'($urandom_range(0, 6)) - 3);
               upper[i*DIM + j] = v;
            end else begin
               v = -upper[j*DIM + i];
            end
            send_item(make_cmd(KIND_WRITE, 3'(i), 3'(j), v, 3'($urandom)));
         end
      end
   endtask

   task automatic run_mutations(input int n, input int count);
      repeat (count) begin
         send_item(make_cmd(KIND_MUTATE, 3'($urandom), 3'($urandom), ENTRY_W'($urandom),
                            3'(pick_index(n))));
         repeat ($urandom_range(0, 2))
            send_item(make_cmd(KIND_READ, 3'(pick_index(n)), 3'(pick_index(n)),
                               ENTRY_W'($urandom), 3'($urandom)));
      end
   endtask

   task automatic test_directed_cases();
      // every entry of the active bank gets a value before anything reads it
      load_skew(DIM);
      send_item(make_cmd(KIND_WRITE, 3'd0, 3'd0, 16'sh7FFF, 3'd0));
      send_item(make_cmd(KIND_READ, 3'd0, 3'd0, '0, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd7, 3'd7, -16'sd32767, 3'd7));
      send_item(make_cmd(KIND_READ, 3'd7, 3'd7, '0, 3'd7));
      // most negative value is stored, but negating it on the pivot line overflows
      send_item(make_cmd(KIND_WRITE, 3'd3, 3'd4, 16'sh8000, 3'd0));
      send_item(make_cmd(KIND_READ, 3'd3, 3'd4, '0, 3'd0));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd3));
      send_item(make_cmd(KIND_READ, 3'd3, 3'd4, '0, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd3, 3'd4, '0, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd0, 3'd0, '0, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd7, 3'd7, '0, 3'd0));
      // product term pushes an off-pivot entry past the range
      send_item(make_cmd(KIND_WRITE, 3'd1, 3'd2, 16'sd200, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd2, 3'd5, 16'sd200, 3'd0));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd2));
      send_item(make_cmd(KIND_WRITE, 3'd1, 3'd2, 16'sd1, 3'd0));
      send_item(make_cmd(KIND_WRITE, 3'd2, 3'd5, -16'sd1, 3'd0));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd2));
      send_item(make_cmd(KIND_READ, 3'd1, 3'd5, '0, 3'd0));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd7));
      send_item(make_cmd(KIND_UNUSED, 3'd7, 3'd7, 16'shFFFF, 3'd7));
      // indexes and pivot beyond a reduced size
      write_matrix_size(4'd4);
      send_item(make_cmd(KIND_WRITE, 3'd5, 3'd5, 16'sd7, 3'd0));
      send_item(make_cmd(KIND_READ, 3'd0, 3'd6, '0, 3'd0));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd6));
      send_item(make_cmd(KIND_MUTATE, 3'd0, 3'd0, '0, 3'd0));
      write_matrix_size(4'd8);
      send_item(make_cmd(KIND_READ, 3'd5, 3'd5, '0, 3'd0));
   endtask

   task automatic test_mutation_chains(input logic [SIZE_W-1:0] sz, input int items);
      int n, goal, pick;
      write_matrix_size(sz);
      n = active_size();
      goal = item_count + items;
      while (item_count < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            load_skew(n);
            run_mutations(n, $urandom_range(2, 8));
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 4))
               send_item(make_cmd(KIND_WRITE, 3'(pick_index(n)), 3'(pick_index(n)),
                                  pick_value(), 3'($urandom)));
            run_mutations(n, $urandom_range(1, 4));
         end else begin
            repeat ($urandom_range(1, 5))
               send_item(make_cmd(KIND_W'($urandom), 3'($urandom), 3'($urandom),
                                  ENTRY_W'($urandom), 3'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_mutation_chains(4'd1, 120);
      test_mutation_chains(4'd3, 130);
      test_mutation_chains(4'd0, 90);
      test_mutation_chains(4'd15, 150);
      test_mutation_chains(4'd5, 130);
      test_mutation_chains(4'd2, 100);
      test_mutation_chains(4'd8, 150);
      test_mutation_chains(4'd6, 130);
      test_mutation_chains(4'd4, 130);
      // last stretch: transactions back to back
      idle_on = 1'b0;
      test_mutation_chains(4'd8, 130);
      wait_idle();
      repeat (2*DIM + DIM*DIM + 16) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         mismatch_count += pending_rsp_q.size();
         $display("%0d expected results never arrived", pending_rsp_q.size());
      end
      if (mismatch_count == 0) begin
         $display("skew_matrix_mutation_top verification clean");
      end else begin
         $display("skew_matrix_mutation_top verification failed");
      end
      $finish;
   end

endmodule
